// File: rtl/core/assert_macros.svh
// Assertion macros used by the sequencer of the stroke extruder.
// Every property is clocked on clk and disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define A_PROP(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("assertion failed");

// A condition that must never be true outside reset.
`define A_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("forbidden condition seen");

`endif

// File: rtl/core/pse_pkg.sv
// ----------------------------------------------------------------------------
// pse_pkg
// Types, widths and vertex codes shared by the stroke extruder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package pse_pkg;

	// Coordinate width, signed Q16.4.
	localparam int COORD_WIDTH = 20;
	localparam int LW_WIDTH    = 12;
	localparam logic [LW_WIDTH-1:0] LW_RESET = 12'd16;

	// Difference and magnitude widths.
	localparam int DIFF_W = COORD_WIDTH + 1;
	localparam int MAG_W  = COORD_WIDTH + 1;
	// Magnitudes are scaled down below 2^NORM_BITS before the length.
	localparam int NORM_BITS = 21;
	// Radicand: sum of two squares, times 65536.
	localparam int RAD_W     = 2 * NORM_BITS + 1 + 16;
	localparam int SQRT_TOP  = (RAD_W - 1) - ((RAD_W - 1) % 2);
	localparam int SQRT_STEPS = SQRT_TOP / 2 + 1;
	localparam int LEN_W     = SQRT_TOP / 2 + 1;
	// Product of magnitude and width, dividend and divisor.
	localparam int PROD_W    = NORM_BITS + LW_WIDTH;
	localparam int DVD_W     = PROD_W + 9;
	localparam int DVS_W     = LEN_W + 1;
	// The offset never exceeds half the width plus one.
	localparam int Q_W       = LW_WIDTH + 1;
	localparam int DIV_STEPS = Q_W;
	localparam int REM_W     = DVS_W + Q_W - 1 > DVD_W ? DVS_W + Q_W - 1 : DVD_W;
	localparam int E_W       = Q_W + 1;
	localparam int SUM_W     = (COORD_WIDTH > E_W ? COORD_WIDTH : E_W) + 3;
	localparam int CNT_W     = $clog2(SQRT_STEPS > DIV_STEPS ? SQRT_STEPS : DIV_STEPS);

	// Texture u codes.
	localparam logic [1:0] TEX_U_ZERO = 2'd0;
	localparam logic [1:0] TEX_U_HALF = 2'd1;
	localparam logic [1:0] TEX_U_ONE  = 2'd2;

	// Strip vertices in emission order.
	typedef enum logic [3:0] {
		V_SW0, V_SW1, V_NW, V_M1, V_P1, V_M2, V_P2, V_SE, V_NE, V_NE0
	} vert_t;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] point_x;
		logic signed [COORD_WIDTH-1:0] point_y;
		logic                          first_point;
		logic                          last_point;
	} in_word_t;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] out_x;
		logic signed [COORD_WIDTH-1:0] out_y;
		logic [1:0]                    tex_u;
		logic                          tex_v;
		logic                          zero_length;
		logic                          last_of_run;
	} out_word_t;

	// Controller to datapath.
	typedef struct packed {
		logic  load_in;
		logic  commit;
		logic  diff;
		logic  clear_e;
		logic  norm_step;
		logic  square;
		logic  rad_init;
		logic  sqrt_step;
		logic  mul;
		logic  div_init;
		logic  div_step;
		logic  emit;
		vert_t vert;
		logic  mark_last;
	} dp_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic zl;
		logic norm_done;
		logic out_free;
	} dp_sts_t;

endpackage

`default_nettype wire

// File: rtl/core/polyline_stroke_extruder.sv
// ----------------------------------------------------------------------------
// polyline_stroke_extruder
// Turns polyline vertices into textured triangle-strip vertices of a thick line.
// ----------------------------------------------------------------------------
// Channel  | Direction | Handshake             | Word
// input    | in        | in_valid / in_ready   | in_word  (point, first, last)
// output   | out       | out_valid / out_ready | out_word (vertex, u, v, flags)
// config   | in        | cfg_write             | cfg_data (line_width)
//
// A start vertex passes through the start state and emits nothing.
// A segment runs the direction arithmetic (one scaling check, which never
// shifts at this coordinate width, a 30-step square root, a 13-step divider),
// then 4 to 10 vertices, one per cycle while the output register is free;
// a zero-length segment skips the arithmetic.
// The output register stalls vertex emission while out_ready is low.
// Reset is asynchronous and leaves the block idle with the width set to 1.0.
`default_nettype none

module polyline_stroke_extruder (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          cfg_write,
	input  wire [pse_pkg::LW_WIDTH-1:0]  cfg_data,
	input  wire                          in_valid,
	output logic                         in_ready,
	input  pse_pkg::in_word_t            in_word,
	output logic                         out_valid,
	input  wire                          out_ready,
	output pse_pkg::out_word_t           out_word
);
	import pse_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	pse_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.first_point (in_word.first_point),
		.last_point  (in_word.last_point),
		.sts         (sts),
		.cmd         (cmd)
	);

	pse_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_data  (cfg_data),
		.in_word   (in_word),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word)
	);

endmodule

`default_nettype wire

// File: rtl/core/pse_datapath.sv
// ----------------------------------------------------------------------------
// pse_datapath
// Point registers, direction arithmetic (scaling, square root, division),
// vertex offset selection with saturation, and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pse_datapath (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            cfg_write,
	input  wire [pse_pkg::LW_WIDTH-1:0]    cfg_data,
	input  pse_pkg::in_word_t              in_word,
	input  pse_pkg::dp_cmd_t               cmd,
	output pse_pkg::dp_sts_t               sts,
	output logic                           out_valid,
	input  wire                            out_ready,
	output pse_pkg::out_word_t             out_word
);
	import pse_pkg::*;

	logic [LW_WIDTH-1:0]           lw_q;
	logic signed [COORD_WIDTH-1:0] cur_x_q, cur_y_q, prev_x_q, prev_y_q;
	logic [MAG_W-1:0]              mx_q, my_q;
	logic                          sx_q, sy_q, zl_q;
	logic [2*NORM_BITS-1:0]        sqx_q, sqy_q;
	logic [RAD_W-1:0]              rad_q, res_q, bit_q;
	logic [PROD_W-1:0]             px_q, py_q;
	logic [REM_W-1:0]              remx_q, remy_q, dsh_q;
	logic [Q_W-1:0]                qx_q, qy_q;
	logic                          out_valid_q;
	out_word_t                     out_q;

	logic signed [DIFF_W-1:0]      dx, dy;
	logic [MAG_W+NORM_BITS-1:0]    mx_ext, my_ext;
	logic [RAD_W-1:0]              trial;
	logic [LEN_W-1:0]              len;
	logic [DVD_W-1:0]              dvd_x, dvd_y;
	logic signed [SUM_W-1:0]       e_s, f_s, base_x, base_y, off_x, off_y, sum_x, sum_y;
	logic [1:0]                    u_c;
	logic                          v_c;

	// Stroke width register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lw_q <= LW_RESET;
		end else if (cfg_write) begin
			lw_q <= cfg_data;
		end
	end

	// Segment difference and scaling test.
	assign dx     = DIFF_W'(cur_x_q) - DIFF_W'(prev_x_q);
	assign dy     = DIFF_W'(cur_y_q) - DIFF_W'(prev_y_q);
	assign mx_ext = {{NORM_BITS{1'b0}}, mx_q};
	assign my_ext = {{NORM_BITS{1'b0}}, my_q};
	assign trial  = res_q + bit_q;
	assign len    = res_q[LEN_W-1:0];
	assign dvd_x  = {1'b0, px_q, 8'b0} + DVD_W'(len);
	assign dvd_y  = {1'b0, py_q, 8'b0} + DVD_W'(len);

	assign sts.zl        = zl_q;
	assign sts.norm_done = ((mx_ext >> NORM_BITS) == '0) && ((my_ext >> NORM_BITS) == '0);
	assign sts.out_free  = !out_valid_q || out_ready;

	// Point registers and the iterative direction unit.
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			cur_x_q <= in_word.point_x;
			cur_y_q <= in_word.point_y;
		end
		if (cmd.commit) begin
			prev_x_q <= cur_x_q;
			prev_y_q <= cur_y_q;
		end
		if (cmd.diff) begin
			sx_q <= dx[DIFF_W-1];
			sy_q <= dy[DIFF_W-1];
			mx_q <= dx[DIFF_W-1] ? MAG_W'(-dx) : MAG_W'(dx);
			my_q <= dy[DIFF_W-1] ? MAG_W'(-dy) : MAG_W'(dy);
			zl_q <= (dx == '0) && (dy == '0);
		end
		if (cmd.norm_step) begin
			mx_q <= mx_q >> 1;
			my_q <= my_q >> 1;
		end
		if (cmd.square) begin
			sqx_q <= mx_q[NORM_BITS-1:0] * mx_q[NORM_BITS-1:0];
			sqy_q <= my_q[NORM_BITS-1:0] * my_q[NORM_BITS-1:0];
		end
		if (cmd.rad_init) begin
			rad_q <= {(RAD_W - 16)'(sqx_q) + (RAD_W - 16)'(sqy_q), 16'b0};
			res_q <= '0;
			bit_q <= RAD_W'(1) << SQRT_TOP;
		end
		// One step of the digit-by-digit square root.
		if (cmd.sqrt_step) begin
			if (rad_q >= trial) begin
				rad_q <= rad_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
		if (cmd.mul) begin
			px_q <= mx_q[NORM_BITS-1:0] * lw_q;
			py_q <= my_q[NORM_BITS-1:0] * lw_q;
		end
		if (cmd.div_init) begin
			remx_q <= REM_W'(dvd_x);
			remy_q <= REM_W'(dvd_y);
			dsh_q  <= REM_W'({len, 1'b0}) << (Q_W - 1);
			qx_q   <= '0;
			qy_q   <= '0;
		end
		// One quotient bit per step for both axes.
		if (cmd.div_step) begin
			if (remx_q >= dsh_q) begin
				remx_q <= remx_q - dsh_q;
			end
			if (remy_q >= dsh_q) begin
				remy_q <= remy_q - dsh_q;
			end
			qx_q  <= {qx_q[Q_W-2:0], remx_q >= dsh_q};
			qy_q  <= {qy_q[Q_W-2:0], remy_q >= dsh_q};
			dsh_q <= dsh_q >> 1;
		end
		if (cmd.clear_e) begin
			qx_q <= '0;
			qy_q <= '0;
		end
	end

	// Signed offset e and vertex selection.
	always_comb begin
		e_s = sx_q ? -SUM_W'(qx_q) : SUM_W'(qx_q);
		f_s = sy_q ? -SUM_W'(qy_q) : SUM_W'(qy_q);
		base_x = SUM_W'(cur_x_q);
		base_y = SUM_W'(cur_y_q);
		off_x  = '0;
		off_y  = '0;
		u_c    = TEX_U_HALF;
		v_c    = 1'b0;
		unique case (cmd.vert)
			V_SW0, V_SW1: begin
				base_x = SUM_W'(prev_x_q);
				base_y = SUM_W'(prev_y_q);
				off_x  = f_s - e_s;
				off_y  = -e_s - f_s;
				u_c    = TEX_U_ZERO;
			end
			V_NW: begin
				base_x = SUM_W'(prev_x_q);
				base_y = SUM_W'(prev_y_q);
				off_x  = -f_s - e_s;
				off_y  = e_s - f_s;
				u_c    = TEX_U_ZERO;
				v_c    = 1'b1;
			end
			V_M1: begin
				base_x = SUM_W'(prev_x_q);
				base_y = SUM_W'(prev_y_q);
				off_x  = f_s;
				off_y  = -e_s;
			end
			V_P1: begin
				base_x = SUM_W'(prev_x_q);
				base_y = SUM_W'(prev_y_q);
				off_x  = -f_s;
				off_y  = e_s;
				v_c    = 1'b1;
			end
			V_M2: begin
				off_x = f_s;
				off_y = -e_s;
			end
			V_P2: begin
				off_x = -f_s;
				off_y = e_s;
				v_c   = 1'b1;
			end
			V_SE: begin
				off_x = e_s + f_s;
				off_y = f_s - e_s;
				u_c   = TEX_U_ONE;
			end
			V_NE: begin
				off_x = e_s - f_s;
				off_y = e_s + f_s;
				u_c   = TEX_U_ONE;
				v_c   = 1'b1;
			end
			V_NE0: begin
				off_x = e_s - f_s;
				off_y = e_s + f_s;
				u_c   = TEX_U_ZERO;
			end
			default: begin
				off_x = '0;
				off_y = '0;
			end
		endcase
		sum_x = base_x + off_x;
		sum_y = base_y + off_y;
	end

	function automatic logic signed [COORD_WIDTH-1:0] sat(input logic signed [SUM_W-1:0] s);
		logic [SUM_W-COORD_WIDTH:0] top;
		top = s[SUM_W-1:COORD_WIDTH-1];
		if ((top == '0) || (top == '1)) begin
			return s[COORD_WIDTH-1:0];
		end
		return s[SUM_W-1] ? {1'b1, {(COORD_WIDTH-1){1'b0}}}
		                  : {1'b0, {(COORD_WIDTH-1){1'b1}}};
	endfunction

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q.out_x       <= sat(sum_x);
			out_q.out_y       <= sat(sum_y);
			out_q.tex_u       <= u_c;
			out_q.tex_v       <= v_c;
			out_q.zero_length <= zl_q;
			out_q.last_of_run <= cmd.mark_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_q;

endmodule

`default_nettype wire

// File: rtl/core/pse_ctrl.sv
// ----------------------------------------------------------------------------
// pse_ctrl
// Sequencer: takes an input word, runs the direction unit step by step and
// walks through the strip vertices of the segment.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module pse_ctrl (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_ready,
	input  wire               first_point,
	input  wire               last_point,
	input  pse_pkg::dp_sts_t  sts,
	output pse_pkg::dp_cmd_t  cmd
);
	import pse_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_START, S_DIFF, S_NORM, S_SQ, S_RAD, S_SQRT,
		S_MUL, S_DINIT, S_DIV, S_EMIT
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             last_q, have_prev_q, on_first_q;
	vert_t            vert_q, end_v;
	logic             accept;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE);
	assign end_v    = last_q ? V_NE0 : V_P2;

	// Commands decoded from the state.
	always_comb begin
		cmd           = '0;
		cmd.vert      = vert_q;
		cmd.mark_last = (vert_q == end_v);
		cmd.load_in   = accept;
		unique case (state_q)
			S_START: cmd.commit    = 1'b1;
			S_DIFF:  cmd.diff      = 1'b1;
			S_NORM: begin
				cmd.clear_e   = sts.zl;
				cmd.norm_step = !sts.zl && !sts.norm_done;
			end
			S_SQ:    cmd.square    = 1'b1;
			S_RAD:   cmd.rad_init  = 1'b1;
			S_SQRT:  cmd.sqrt_step = 1'b1;
			S_MUL:   cmd.mul       = 1'b1;
			S_DINIT: cmd.div_init  = 1'b1;
			S_DIV:   cmd.div_step  = 1'b1;
			S_EMIT: begin
				cmd.emit   = sts.out_free;
				cmd.commit = sts.out_free && (vert_q == end_v);
			end
			default: cmd.load_in = accept;
		endcase
	end

	// State and sequencing registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			last_q      <= 1'b0;
			have_prev_q <= 1'b0;
			on_first_q  <= 1'b0;
			vert_q      <= V_SW0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						last_q  <= last_point;
						state_q <= (first_point || !have_prev_q) ? S_START : S_DIFF;
					end
				end
				S_START: begin
					have_prev_q <= !last_q;
					on_first_q  <= 1'b1;
					state_q     <= S_IDLE;
				end
				S_DIFF: state_q <= S_NORM;
				S_NORM: begin
					vert_q <= on_first_q ? V_SW0 : V_M1;
					if (sts.zl) begin
						state_q <= S_EMIT;
					end else if (sts.norm_done) begin
						state_q <= S_SQ;
					end
				end
				S_SQ: state_q <= S_RAD;
				S_RAD: begin
					cnt_q   <= CNT_W'(SQRT_STEPS - 1);
					state_q <= S_SQRT;
				end
				S_SQRT: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: state_q <= S_DINIT;
				S_DINIT: begin
					cnt_q   <= CNT_W'(DIV_STEPS - 1);
					state_q <= S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (sts.out_free) begin
						if (vert_q == end_v) begin
							on_first_q  <= 1'b0;
							have_prev_q <= !last_q;
							state_q     <= S_IDLE;
						end else begin
							vert_q <= vert_t'(vert_q + 4'd1);
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// An accepted word keeps the input closed on the next cycle.
	`A_PROP(a_accept_busy, accept |=> !in_ready)
	// Vertices are never produced while the input is open.
	`A_NEVER(a_no_overlap, in_ready && cmd.emit)
	// A vertex is loaded only when the output register can take it.
	`A_PROP(a_emit_free, cmd.emit |-> sts.out_free)

endmodule

`default_nettype wire

// File: tb/pse_checker.sv
// ----------------------------------------------------------------------------
// pse_checker
// Watches the vertex and strip channels of the stroke extruder, predicts the
// strip vertices that each accepted vertex produces and compares them in order.
// ----------------------------------------------------------------------------
`default_nettype none

module pse_checker (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                cfg_write,
	input  wire [pse_pkg::LW_WIDTH-1:0]        cfg_data,
	input  wire                                in_valid,
	input  wire                                in_ready,
	input  pse_pkg::in_word_t                  in_word,
	input  wire                                out_valid,
	input  wire                                out_ready,
	input  pse_pkg::out_word_t                 out_word,
	output int                                 fail_count,
	output int                                 vertices_pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import pse_pkg::*;

	localparam longint COORD_MAX = (64'sd1 <<< (COORD_WIDTH - 1)) - 1;
	localparam longint COORD_MIN = -COORD_MAX - 1;

	// Predictor state, mirrors the block after reset.
	logic [LW_WIDTH-1:0] width_q;
	longint              held_x, held_y;
	bit                  holding, opening_segment;
	out_word_t           strip_queue[$];

	function automatic longint root_floor(longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic logic [COORD_WIDTH-1:0] clamp_coord(longint v);
		if (v > COORD_MAX) v = COORD_MAX;
		if (v < COORD_MIN) v = COORD_MIN;
		return v[COORD_WIDTH-1:0];
	endfunction

	task automatic push_vertex(longint x, longint y, logic [1:0] u, bit v, bit zl);
		out_word_t w;
		w.out_x = clamp_coord(x);
		w.out_y = clamp_coord(y);
		w.tex_u = u;
		w.tex_v = v;
		w.zero_length = zl;
		w.last_of_run = 1'b0;
		strip_queue.push_back(w);
	endtask

	// Works out the strip vertices for one accepted vertex word.
	task automatic extrude_vertex(in_word_t w);
		longint x, y, dx, dy, ex, ey, nx, ny, nex, ney, nwx, nwy;
		longint unsigned mx, my, len, qx, qy;
		bit zl;
		x = longint'(w.point_x);
		y = longint'(w.point_y);
		if (w.first_point || !holding) begin
			held_x = x;
			held_y = y;
			holding = !w.last_point;
			opening_segment = 1;
			return;
		end
		dx = x - held_x;
		dy = y - held_y;
		zl = (dx == 0 && dy == 0);
		ex = 0;
		ey = 0;
		if (!zl) begin
			mx = dx < 0 ? -dx : dx;
			my = dy < 0 ? -dy : dy;
			while (mx >= (64'd1 << 21) || my >= (64'd1 << 21)) begin
				mx >>= 1;
				my >>= 1;
			end
			len = root_floor((mx * mx + my * my) << 16);
			if (len != 0) begin
				qx = (2 * mx * width_q * 128 + len) / (2 * len);
				qy = (2 * my * width_q * 128 + len) / (2 * len);
				ex = dx < 0 ? -longint'(qx) : longint'(qx);
				ey = dy < 0 ? -longint'(qy) : longint'(qy);
			end
		end
		nx = -ey;
		ny = ex;
		nex = nx + ex;
		ney = ny + ey;
		nwx = nx - ex;
		nwy = ny - ey;
		if (opening_segment) begin
			push_vertex(held_x - nex, held_y - ney, TEX_U_ZERO, 0, zl);
			push_vertex(held_x - nex, held_y - ney, TEX_U_ZERO, 0, zl);
			push_vertex(held_x + nwx, held_y + nwy, TEX_U_ZERO, 1, zl);
		end
		push_vertex(held_x - nx, held_y - ny, TEX_U_HALF, 0, zl);
		push_vertex(held_x + nx, held_y + ny, TEX_U_HALF, 1, zl);
		push_vertex(x - nx, y - ny, TEX_U_HALF, 0, zl);
		push_vertex(x + nx, y + ny, TEX_U_HALF, 1, zl);
		if (w.last_point) begin
			push_vertex(x - nwx, y - nwy, TEX_U_ONE, 0, zl);
			push_vertex(x + nex, y + ney, TEX_U_ONE, 1, zl);
			push_vertex(x + nex, y + ney, TEX_U_ZERO, 0, zl);
		end
		strip_queue[$].last_of_run = 1'b1;
		held_x = x;
		held_y = y;
		opening_segment = 0;
		holding = !w.last_point;
	endtask

	// Tracks the width register, predicts on input words, checks output words.
	always @(posedge clk or negedge arst_n) begin
		out_word_t want;
		if (!arst_n) begin
			width_q = LW_RESET;
			held_x = 0;
			held_y = 0;
			holding = 0;
			opening_segment = 0;
			strip_queue.delete();
			fail_count = 0;
		end else begin
			if (cfg_write) width_q = cfg_data;
			if (in_valid && in_ready) extrude_vertex(in_word);
			if (out_valid && out_ready) begin
				if (strip_queue.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected output word %h", out_word);
				end else begin
					want = strip_queue.pop_front();
					if (out_word !== want) begin
						fail_count++;
						if (fail_count <= 10)
							$display({"mismatch: x %0d/%0d y %0d/%0d u %0d/%0d",
								" v %0d/%0d zl %0d/%0d last %0d/%0d (exp/act)"},
								want.out_x, out_word.out_x, want.out_y, out_word.out_y,
								want.tex_u, out_word.tex_u, want.tex_v, out_word.tex_v,
								want.zero_length, out_word.zero_length,
								want.last_of_run, out_word.last_of_run);
					end
				end
			end
		end
		vertices_pending = strip_queue.size();
	end

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives polylines into the stroke extruder under several widths, with random
// gaps on both channels; the checker predicts and compares the strip words.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import pse_pkg::*;

	logic                clk = 0;
	logic                arst_n = 0;
	logic                cfg_write = 0;
	logic [LW_WIDTH-1:0] cfg_data = '0;
	logic                in_valid = 0;
	logic                in_ready;
	in_word_t            in_word = '0;
	logic                out_valid;
	logic                out_ready = 0;
	out_word_t           out_word;
	int                  fail_count;
	int                  vertices_pending;
	bit                  stim_done = 0;
	bit                  rx_pause = 0;

	always #5 clk = ~clk;

	polyline_stroke_extruder dut (
		.clk(clk), .arst_n(arst_n), .cfg_write(cfg_write), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
		.out_valid(out_valid), .out_ready(out_ready), .out_word(out_word)
	);

	pse_checker checker_i (
		.clk(clk), .arst_n(arst_n), .cfg_write(cfg_write), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
		.out_valid(out_valid), .out_ready(out_ready), .out_word(out_word),
		.fail_count(fail_count), .vertices_pending(vertices_pending)
	);

	function automatic int gap_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// Sends one vertex word, after a random gap, and waits for its acceptance.
	// The word goes out on a later falling edge than the one that dropped the previous;
	// the block is never ready on the cycle after an acceptance anyway.
	task automatic send_vertex(logic signed [COORD_WIDTH-1:0] x,
			logic signed [COORD_WIDTH-1:0] y, bit first, bit last);
		int gap;
		gap = gap_length();
		repeat (gap + 1) @(negedge clk);
		in_word <= '{point_x: x, point_y: y, first_point: first, last_point: last};
		in_valid <= 1;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		in_valid <= 0;
	endtask

	// Waits for every strip word, then for in-flight work, then writes the width.
	task automatic write_width(logic [LW_WIDTH-1:0] w);
		while (vertices_pending != 0) @(negedge clk);
		repeat (80) @(negedge clk);
		cfg_data <= w;
		cfg_write <= 1;
		@(negedge clk);
		cfg_write <= 0;
	endtask

	function automatic logic signed [COORD_WIDTH-1:0] rand_coord();
		int r;
		r = $urandom_range(0, 9);
		if (r < 2) return COORD_WIDTH'($urandom);
		if (r < 3) return $urandom_range(0, 1) ? 20'sh7FFFF : 20'sh80000;
		return $signed(20'($urandom_range(0, 4000))) - 20'sd2000;
	endfunction

	// Output side: ready toggles with random stalls, some stretches steady.
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (rx_pause) begin
				out_ready <= 1;
			end else begin
				gap = gap_length();
				if (gap == 0) out_ready <= 1;
				else begin
					out_ready <= 0;
					repeat (gap - 1) @(negedge clk);
					@(negedge clk);
					out_ready <= 1;
				end
			end
		end
	end

	// Stimulus: directed cases, then random polylines under several widths.
	initial begin
		int n, len, k, wi;
		logic signed [COORD_WIDTH-1:0] x, y;
		logic [LW_WIDTH-1:0] widths[4];
		widths = '{12'd0, 12'd4095, 12'd1, 12'd40};
		repeat (5) @(negedge clk);
		arst_n <= 1;
		@(negedge clk);
		// Reset width, ordinary path, then extremes and zero-length segments.
		send_vertex(0, 0, 1, 0);
		send_vertex(160, 0, 0, 0);
		send_vertex(160, 160, 0, 0);
		send_vertex(160, 160, 0, 0);
		send_vertex(-50, 300, 0, 1);
		send_vertex(5, 5, 1, 1);
		send_vertex(7, 7, 0, 0);
		send_vertex(20'sh80000, 20'sh80000, 0, 0);
		send_vertex(20'sh7FFFF, 20'sh7FFFF, 0, 0);
		send_vertex(1, -1, 1, 0);
		send_vertex(20'sh7FFFF, 20'sh80000, 0, 1);
		send_vertex(3, 3, 0, 1);
		send_vertex(-3, 9, 0, 0);
		send_vertex(-3, 10, 0, 1);
		write_width(12'd4095);
		send_vertex(20'sh7FFFF, 0, 1, 0);
		send_vertex(20'sh7FFF0, 1, 0, 0);
		send_vertex(20'sh80000, 20'sh7FFFF, 0, 0);
		send_vertex(20'sh80000, 20'sh7FFFF, 0, 1);
		// Hold off until the block has drained completely.
		rx_pause = 1;
		while (vertices_pending != 0) @(negedge clk);
		rx_pause = 0;
		n = 0;
		wi = 0;
		while (n < 220) begin
			if (n % 55 == 0) begin
				write_width(widths[wi % 4]);
				wi++;
			end
			if ($urandom_range(0, 9) == 0) begin
				send_vertex(rand_coord(), rand_coord(), 1'($urandom), 1'($urandom));
				n++;
			end else begin
				len = $urandom_range(2, 6);
				x = rand_coord();
				y = rand_coord();
				send_vertex(x, y, 1, 0);
				for (k = 1; k < len; k++) begin
					if ($urandom_range(0, 7) != 0) begin
						x = $urandom_range(0, 4) == 0 ? rand_coord()
							: x + $signed(20'($urandom_range(0, 600))) - 20'sd300;
						y = $urandom_range(0, 4) == 0 ? rand_coord()
							: y + $signed(20'($urandom_range(0, 600))) - 20'sd300;
					end
					send_vertex(x, y, 0, k == len - 1);
				end
				n += len;
			end
		end
		stim_done = 1;
	end

	// Verdict once everything has drained.
	initial begin
		wait (stim_done);
		while (vertices_pending != 0) @(negedge clk);
		repeat (100) @(negedge clk);
		if (fail_count == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

	initial begin
		#20ms;
		$display("tb_top: errors");
		$finish;
	end

endmodule

`default_nettype wire

// File: polyline_stroke_extruder.f
+incdir+rtl/core
rtl/core/pse_pkg.sv
rtl/core/pse_datapath.sv
rtl/core/pse_ctrl.sv
rtl/core/polyline_stroke_extruder.sv
tb/pse_checker.sv
tb/tb_top.sv
